FILE: hw/rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

  // Bounding-range overlap flags, worked out in the first stage and carried
  // down the pipe to the final decision.
  typedef struct packed {
    logic x_meet;
    logic y_meet;
  } sit_meet_t;

endpackage

FILE: hw/rtl/sit_if.sv
// ----------------------------------------------------------------------------
// Segment intersection test channels
// Valid/ready channels for segment pairs in and touch results out.
// ----------------------------------------------------------------------------
interface seg_pair_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_a_start_x;
  logic signed [COORD_WIDTH-1:0] seg_a_start_y;
  logic signed [COORD_WIDTH-1:0] seg_a_end_x;
  logic signed [COORD_WIDTH-1:0] seg_a_end_y;
  logic signed [COORD_WIDTH-1:0] seg_b_start_x;
  logic signed [COORD_WIDTH-1:0] seg_b_start_y;
  logic signed [COORD_WIDTH-1:0] seg_b_end_x;
  logic signed [COORD_WIDTH-1:0] seg_b_end_y;

  modport source (
    output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    input  ready
  );
  modport sink (
    input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    output ready
  );
endinterface

interface touch_if;
  logic valid;
  logic ready;
  logic touches;

  modport source (output valid, touches, input ready);
  modport sink (input valid, touches, output ready);
endinterface

FILE: hw/rtl/sit_diff.sv
// ----------------------------------------------------------------------------
// Segment intersection test, stage 1
// Direction and offset vectors, plus axis range overlap of the two segments.
// ----------------------------------------------------------------------------
module sit_diff import sit_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  seg_pair_if.sink                    in_ch,
  output logic                        s1_valid,
  input  logic                        s1_ready,
  output logic signed [COORD_WIDTH:0] dax,
  output logic signed [COORD_WIDTH:0] day,
  output logic signed [COORD_WIDTH:0] dbx,
  output logic signed [COORD_WIDTH:0] dby,
  output logic signed [COORD_WIDTH:0] wx,
  output logic signed [COORD_WIDTH:0] wy,
  output sit_meet_t                   meet
);

  localparam int DW = COORD_WIDTH + 1;

  logic                 valid_r;
  logic                 stage_ready;
  logic signed [DW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic signed [DW-1:0] dax_r, day_r, dbx_r, dby_r, wx_r, wy_r;
  sit_meet_t            meet_r;
  sit_meet_t            meet_nxt;

  assign ax0 = {in_ch.seg_a_start_x[COORD_WIDTH-1], in_ch.seg_a_start_x};
  assign ay0 = {in_ch.seg_a_start_y[COORD_WIDTH-1], in_ch.seg_a_start_y};
  assign ax1 = {in_ch.seg_a_end_x[COORD_WIDTH-1], in_ch.seg_a_end_x};
  assign ay1 = {in_ch.seg_a_end_y[COORD_WIDTH-1], in_ch.seg_a_end_y};
  assign bx0 = {in_ch.seg_b_start_x[COORD_WIDTH-1], in_ch.seg_b_start_x};
  assign by0 = {in_ch.seg_b_start_y[COORD_WIDTH-1], in_ch.seg_b_start_y};
  assign bx1 = {in_ch.seg_b_end_x[COORD_WIDTH-1], in_ch.seg_b_end_x};
  assign by1 = {in_ch.seg_b_end_y[COORD_WIDTH-1], in_ch.seg_b_end_y};

  // max(p) >= min(q) holds exactly when some endpoint of p is at or above
  // some endpoint of q, so four parallel compares per direction suffice.
  always_comb begin
    meet_nxt.x_meet = ((ax0 >= bx0) || (ax0 >= bx1) || (ax1 >= bx0) || (ax1 >= bx1)) &&
                      ((bx0 >= ax0) || (bx0 >= ax1) || (bx1 >= ax0) || (bx1 >= ax1));
    meet_nxt.y_meet = ((ay0 >= by0) || (ay0 >= by1) || (ay1 >= by0) || (ay1 >= by1)) &&
                      ((by0 >= ay0) || (by0 >= ay1) || (by1 >= ay0) || (by1 >= ay1));
  end

  assign stage_ready = !valid_r || s1_ready;
  assign in_ch.ready = stage_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (stage_ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && in_ch.valid) begin
      dax_r  <= ax1 - ax0;
      day_r  <= ay1 - ay0;
      dbx_r  <= bx1 - bx0;
      dby_r  <= by1 - by0;
      wx_r   <= bx0 - ax0;
      wy_r   <= by0 - ay0;
      meet_r <= meet_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign dax      = dax_r;
  assign day      = day_r;
  assign dbx      = dbx_r;
  assign dby      = dby_r;
  assign wx       = wx_r;
  assign wy       = wy_r;
  assign meet     = meet_r;

endmodule

FILE: hw/rtl/sit_prod.sv
// ----------------------------------------------------------------------------
// Segment intersection test, stages 2 and 3
// Six registered products, then the determinant and both parameter numerators.
// ----------------------------------------------------------------------------
module sit_prod import sit_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s1_valid,
  output logic                              s1_ready,
  input  logic signed [COORD_WIDTH:0]       dax,
  input  logic signed [COORD_WIDTH:0]       day,
  input  logic signed [COORD_WIDTH:0]       dbx,
  input  logic signed [COORD_WIDTH:0]       dby,
  input  logic signed [COORD_WIDTH:0]       wx,
  input  logic signed [COORD_WIDTH:0]       wy,
  input  sit_meet_t                         meet_in,
  output logic                              s3_valid,
  input  logic                              s3_ready,
  output logic signed [2*COORD_WIDTH+2:0]   det,
  output logic signed [2*COORD_WIDTH+2:0]   tn,
  output logic signed [2*COORD_WIDTH+2:0]   un,
  output sit_meet_t                         meet_out
);

  localparam int PW = 2 * COORD_WIDTH + 2;
  localparam int SW = PW + 1;

  logic                 s2_valid_r;
  logic                 s2_ready;
  logic signed [PW-1:0] m_ad_r, m_bc_r, m_tn1_r, m_tn2_r, m_un1_r, m_un2_r;
  sit_meet_t            s2_meet_r;

  logic                 s3_valid_r;
  logic                 s3_stage_ready;
  logic signed [SW-1:0] det_r, tn_r, un_r;
  sit_meet_t            s3_meet_r;

  assign s2_ready       = !s2_valid_r || s3_stage_ready;
  assign s3_stage_ready = !s3_valid_r || s3_ready;
  assign s1_ready       = s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= s1_valid;
      end
      if (s3_stage_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      m_ad_r    <= PW'(dax * dby);
      m_bc_r    <= PW'(day * dbx);
      m_tn1_r   <= PW'(wx * dby);
      m_tn2_r   <= PW'(wy * dbx);
      m_un1_r   <= PW'(wx * day);
      m_un2_r   <= PW'(wy * dax);
      s2_meet_r <= meet_in;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_stage_ready && s2_valid_r) begin
      det_r     <= {m_ad_r[PW-1], m_ad_r} - {m_bc_r[PW-1], m_bc_r};
      tn_r      <= {m_tn1_r[PW-1], m_tn1_r} - {m_tn2_r[PW-1], m_tn2_r};
      un_r      <= {m_un1_r[PW-1], m_un1_r} - {m_un2_r[PW-1], m_un2_r};
      s3_meet_r <= s2_meet_r;
    end
  end

  assign s3_valid = s3_valid_r;
  assign det      = det_r;
  assign tn       = tn_r;
  assign un       = un_r;
  assign meet_out = s3_meet_r;

`ifndef SYNTHESIS
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s3_stage_ready |=> s2_valid_r && $stable(m_ad_r) && $stable(m_tn1_r))
    else $error("stage 2 products changed while stalled");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !s3_ready |=> s3_valid_r && $stable(det_r) && $stable(un_r))
    else $error("stage 3 sums changed while stalled");

  a_s3_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s3_valid_r) |-> $past(s2_valid_r))
    else $error("stage 3 became valid with no item in stage 2");
`endif

endmodule

FILE: hw/rtl/sit_cmp.sv
// ----------------------------------------------------------------------------
// Segment intersection test, stage 4
// Sign-aware bounds test or collinear overlap test into the output register.
// ----------------------------------------------------------------------------
module sit_cmp import sit_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s3_valid,
  output logic                            s3_ready,
  input  logic signed [2*COORD_WIDTH+2:0] det,
  input  logic signed [2*COORD_WIDTH+2:0] tn,
  input  logic signed [2*COORD_WIDTH+2:0] un,
  input  sit_meet_t                       meet,
  touch_if.source                         out_ch
);

  localparam int SW = 2 * COORD_WIDTH + 3;

  logic                 valid_r;
  logic                 touches_r;
  logic                 stage_ready;
  logic                 det_zero;
  logic                 hit_pos;
  logic                 hit_neg;
  logic                 hit_par;
  logic                 hit_nxt;
  logic signed [SW-1:0] zero_s;

  assign zero_s   = '0;
  assign det_zero = (det == zero_s);

  // For a negative determinant the bounds flip instead of negating all three.
  assign hit_pos = (tn >= zero_s) && (tn <= det) && (un >= zero_s) && (un <= det);
  assign hit_neg = (tn <= zero_s) && (tn >= det) && (un <= zero_s) && (un >= det);

  // With a zero determinant, tn and un are the negated collinearity crosses.
  assign hit_par = (tn == zero_s) && (un == zero_s) && meet.x_meet && meet.y_meet;

  always_comb begin
    priority if (det_zero) begin
      hit_nxt = hit_par;
    end else if (det[SW-1]) begin
      hit_nxt = hit_neg;
    end else begin
      hit_nxt = hit_pos;
    end
  end

  assign stage_ready = !valid_r || out_ch.ready;
  assign s3_ready    = stage_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (stage_ready) begin
      valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && s3_valid) begin
      touches_r <= hit_nxt;
    end
  end

  assign out_ch.valid   = valid_r;
  assign out_ch.touches = touches_r;

endmodule

FILE: hw/rtl/segment_intersection_test_top.sv
// ----------------------------------------------------------------------------
// Segment intersection test
// Reports whether two closed integer segments share at least one point.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one segment pair per beat: endpoints of A and B as signed
//   COORD_WIDTH-bit coordinates. out_ch carries one touches bit per pair, in
//   the order the pairs were taken.
//   The pipe has four register stages: vector differences and axis range
//   overlap, six products, the determinant and two numerators, then the
//   bounds test into the output register, which drives out_ch.valid. One
//   pair is taken every cycle while the receiver keeps up; a stall at
//   out_ch holds the flow.
//   Each stage holds its own valid bit and is ready whenever it is empty or
//   its successor moves, so bubbles close up and new pairs keep flowing
//   while a result waits at the output.
//   When the receiver stalls, the output register holds its beat and the
//   stages behind it fill, after which in_ch.ready drops. Nothing is lost
//   or repeated.
//   Synchronous reset (rst_n low) empties every stage; the block holds no
//   other state.
// ----------------------------------------------------------------------------
module segment_intersection_test_top import sit_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  seg_pair_if.sink in_ch,
  touch_if.source  out_ch
);

  localparam int SW = 2 * COORD_WIDTH + 3;

  logic                        s1_valid, s1_ready;
  logic                        s3_valid, s3_ready;
  logic signed [COORD_WIDTH:0] dax, day, dbx, dby, wx, wy;
  logic signed [SW-1:0]        det, tn, un;
  sit_meet_t                   meet_s1;
  sit_meet_t                   meet_s3;

  sit_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .dax      (dax),
    .day      (day),
    .dbx      (dbx),
    .dby      (dby),
    .wx       (wx),
    .wy       (wy),
    .meet     (meet_s1)
  );

  sit_prod #(.COORD_WIDTH(COORD_WIDTH)) u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .dax      (dax),
    .day      (day),
    .dbx      (dbx),
    .dby      (dby),
    .wx       (wx),
    .wy       (wy),
    .meet_in  (meet_s1),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .det      (det),
    .tn       (tn),
    .un       (un),
    .meet_out (meet_s3)
  );

  sit_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .det      (det),
    .tn       (tn),
    .un       (un),
    .meet     (meet_s3),
    .out_ch   (out_ch)
  );

endmodule

FILE: sim/tb_segment_intersection_test_top.sv
// ----------------------------------------------------------------------------
// Segment intersection test bench
// Streams segment pairs into the pipe and compares every touches bit with an
// in-bench predictor, under random sender gaps, receiver stalls and one long
// output hold-off that fills the pipe and stalls its input.
// ----------------------------------------------------------------------------
module tb_segment_intersection_test_top;

  localparam int CW             = 16;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
  } seg_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  int   src_idle_pct;
  int   snk_idle_pct;
  logic holdoff_req;

  bit   expected_touch[$];
  int   pairs_sent;
  int   results_checked;
  int   touching_seen;
  int   input_stall_cycles;
  int   mismatch_count;

  seg_pair_if #(.COORD_WIDTH(CW)) pair_ch ();
  touch_if                        touch_ch ();

  segment_intersection_test_top #(.COORD_WIDTH(CW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pair_ch),
    .out_ch (touch_ch)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint cross_prod(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic bit spans_meet(longint p0, longint p1, longint q0, longint q1);
    longint p_lo, p_hi, q_lo, q_hi;
    p_lo = (p0 < p1) ? p0 : p1;
    p_hi = (p0 < p1) ? p1 : p0;
    q_lo = (q0 < q1) ? q0 : q1;
    q_hi = (q0 < q1) ? q1 : q0;
    return (p_hi >= q_lo) && (q_hi >= p_lo);
  endfunction

  function automatic bit predict_touch(seg_pair_t p);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint dax, day, dbx, dby, wx, wy;
    longint det, t_num, u_num;
    ax0 = p.a_start_x; ay0 = p.a_start_y; ax1 = p.a_end_x; ay1 = p.a_end_y;
    bx0 = p.b_start_x; by0 = p.b_start_y; bx1 = p.b_end_x; by1 = p.b_end_y;
    dax = ax1 - ax0; day = ay1 - ay0;
    dbx = bx1 - bx0; dby = by1 - by0;
    wx  = bx0 - ax0; wy  = by0 - ay0;
    det = cross_prod(dax, day, dbx, dby);
    if (det != 0) begin
      t_num = cross_prod(wx, wy, dbx, dby);
      u_num = cross_prod(wx, wy, dax, day);
      // Flip all three so the bounds test only has to handle a positive det.
      if (det < 0) begin
        det   = -det;
        t_num = -t_num;
        u_num = -u_num;
      end
      return (t_num >= 0) && (t_num <= det) && (u_num >= 0) && (u_num <= det);
    end
    // Parallel or degenerate: every endpoint must sit on one line, and the
    // bounding spans must overlap on both axes.
    return (cross_prod(dax, day, wx, wy) == 0) && (cross_prod(dbx, dby, wx, wy) == 0) &&
           spans_meet(ax0, ax1, bx0, bx1) && spans_meet(ay0, ay1, by0, by1);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.a_start_x = ax0[CW-1:0]; p.a_start_y = ay0[CW-1:0];
    p.a_end_x   = ax1[CW-1:0]; p.a_end_y   = ay1[CW-1:0];
    p.b_start_x = bx0[CW-1:0]; p.b_start_y = by0[CW-1:0];
    p.b_end_x   = bx1[CW-1:0]; p.b_end_y   = by1[CW-1:0];
    return p;
  endfunction

  function automatic int irand(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int any_coord();
    return irand(-32768, 32767);
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      6: return 32767;
      default: return any_coord();
    endcase
  endfunction

  // Mixes free pairs with shapes that reach the parallel, collinear,
  // single-point and endpoint-on-segment paths.
  function automatic seg_pair_t random_pair();
    int c[8];
    int ox, oy, dx, dy, lim;
    int t0, t1, s0, s1;
    int shift_x, shift_y;
    case ($urandom_range(0, 9))
      0, 1: begin
        foreach (c[i]) c[i] = any_coord();
      end
      2, 3: begin
        foreach (c[i]) c[i] = irand(-6, 6);
      end
      4: begin
        foreach (c[i]) c[i] = edge_coord();
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          ox = irand(-16000, 16000); oy = irand(-16000, 16000);
          dx = irand(-200, 200);     dy = irand(-200, 200);
          lim = 80;
        end else begin
          ox = irand(-1000, 1000); oy = irand(-1000, 1000);
          dx = irand(-20, 20);     dy = irand(-20, 20);
          lim = 40;
        end
        t0 = irand(-lim, lim); t1 = irand(-lim, lim);
        s0 = irand(-lim, lim); s1 = irand(-lim, lim);
        case ($urandom_range(0, 5))
          0: s0 = t1;                      // shared endpoint
          1: t1 = t0;                      // A is a single point
          2: begin s1 = s0; t1 = t0; end   // both single points
          default: ;
        endcase
        c[0] = ox + t0 * dx; c[1] = oy + t0 * dy;
        c[2] = ox + t1 * dx; c[3] = oy + t1 * dy;
        c[4] = ox + s0 * dx; c[5] = oy + s0 * dy;
        c[6] = ox + s1 * dx; c[7] = oy + s1 * dy;
        case ($urandom_range(0, 3))
          0: begin
            // Shift B by at most one unit on each axis, keeping it parallel.
            shift_x = irand(-1, 1); shift_y = irand(-1, 1);
            c[4] += shift_x; c[6] += shift_x;
            c[5] += shift_y; c[7] += shift_y;
          end
          1: begin
            // B starts on A's line and leaves it: a T junction or a miss.
            c[6] = c[4] + irand(-30, 30);
            c[7] = c[5] + irand(-30, 30);
          end
          default: ;
        endcase
      end
    endcase
    return make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  // Called and returning at a rising edge; valid stays high on return so
  // back-to-back beats need no second assignment in one step.
  task automatic send_pair(input seg_pair_t p);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pair_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pair_ch.valid         <= 1'b1;
    pair_ch.seg_a_start_x <= p.a_start_x;
    pair_ch.seg_a_start_y <= p.a_start_y;
    pair_ch.seg_a_end_x   <= p.a_end_x;
    pair_ch.seg_a_end_y   <= p.a_end_y;
    pair_ch.seg_b_start_x <= p.b_start_x;
    pair_ch.seg_b_start_y <= p.b_start_y;
    pair_ch.seg_b_end_x   <= p.b_end_x;
    pair_ch.seg_b_end_y   <= p.b_end_y;
    do @(posedge clk); while (!pair_ch.ready);
    expected_touch.push_back(predict_touch(p));
    pairs_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_crossing_cases();
    send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));       // proper crossing
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 5));          // T at B's start
    send_pair(make_pair(0, 0, 4, 0, 4, -3, 4, 3));          // A's end on B
    send_pair(make_pair(0, 0, 4, 0, 5, -3, 5, 3));          // one past A's end
    send_pair(make_pair(0, 0, 1, 1, 5, 0, 6, -3));          // lines meet off both
    send_pair(make_pair(3, 7, -2, -9, 8, -1, -6, 2));       // crossing, mixed signs
  endtask

  task automatic test_parallel_and_collinear();
    send_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1));         // parallel, apart
    send_pair(make_pair(10, 0, 0, 0, 12, 0, 5, 0));         // overlap, reversed ends
    send_pair(make_pair(0, 0, 3, 3, 5, 5, 9, 9));           // same line, gap
    send_pair(make_pair(0, 0, 4, 2, 8, 4, 4, 2));           // shared endpoint
    send_pair(make_pair(-100, -50, 100, 50, -2, -1, 2, 1)); // containment
    send_pair(make_pair(0, -5, 0, 5, 0, 100, 0, 5));        // vertical, touching
  endtask

  task automatic test_single_points();
    send_pair(make_pair(3, 3, 3, 3, 0, 0, 6, 6));           // point on B
    send_pair(make_pair(7, 7, 7, 7, 0, 0, 6, 6));           // on the line, past B
    send_pair(make_pair(1, 2, 1, 2, 0, 0, 6, 6));           // off the line
    send_pair(make_pair(0, 0, 6, 6, 6, 6, 6, 6));           // B is A's end
    send_pair(make_pair(-4, 9, -4, 9, -4, 9, -4, 9));       // equal points
    send_pair(make_pair(-4, 9, -4, 9, -4, 8, -4, 8));       // different points
  endtask

  task automatic test_coordinate_extremes();
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(make_pair(-32768, 32767, 32767, 32767, -32768, 32766, 32767, 32766));
    send_pair(make_pair(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32767));
  endtask

  task automatic test_random_traffic(input int pairs, input int src_pct,
                                     input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct <= snk_pct;
    repeat (pairs) send_pair(random_pair());
  endtask

  // The receiver goes quiet for a long stretch while beats keep coming.
  task automatic test_output_holdoff();
    src_idle_pct = 0;
    snk_idle_pct <= 0;
    holdoff_req  <= 1'b1;
    repeat (120) send_pair(random_pair());
  endtask

  // --------------------------------------------------------------------------
  // Receiver ready, with the one-time hold-off counted here
  // --------------------------------------------------------------------------
  initial begin : drive_result_ready
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    touch_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        touch_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        touch_ch.ready <= 1'b0;
      end else if (holdoff_req && !hold_taken) begin
        hold_taken = 1;
        hold_left  = HOLDOFF_CYCLES - 1;
        touch_ch.ready <= 1'b0;
      end else begin
        touch_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  initial begin : check_results
    bit want;
    forever begin
      @(posedge clk);
      if (rst_n && pair_ch.valid && !pair_ch.ready) input_stall_cycles++;
      if (rst_n && touch_ch.valid && touch_ch.ready) begin
        if (expected_touch.size() == 0) begin
          $display("%0t: result beat with nothing expected, touches=%0b",
                   $time, touch_ch.touches);
          mismatch_count++;
        end else begin
          want = expected_touch.pop_front();
          if (touch_ch.touches !== want) begin
            $display("%0t: touches mismatch, expected %0b, got %0b",
                     $time, want, touch_ch.touches);
            mismatch_count++;
          end
          results_checked++;
          if (touch_ch.touches === 1'b1) touching_seen++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles, %0d results still expected",
             CYCLE_LIMIT, expected_touch.size());
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                 <= 1'b0;
    holdoff_req           <= 1'b0;
    snk_idle_pct          <= 0;
    pair_ch.valid         <= 1'b0;
    pair_ch.seg_a_start_x <= '0;
    pair_ch.seg_a_start_y <= '0;
    pair_ch.seg_a_end_x   <= '0;
    pair_ch.seg_a_end_y   <= '0;
    pair_ch.seg_b_start_x <= '0;
    pair_ch.seg_b_start_y <= '0;
    pair_ch.seg_b_end_x   <= '0;
    pair_ch.seg_b_end_y   <= '0;
    src_idle_pct       = 0;
    pairs_sent         = 0;
    results_checked    = 0;
    touching_seen      = 0;
    input_stall_cycles = 0;
    mismatch_count     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 16;
    snk_idle_pct <= 54;
    test_crossing_cases();
    test_parallel_and_collinear();
    test_single_points();
    test_coordinate_extremes();

    test_random_traffic(580, 16, 54);
    test_random_traffic(580, 54, 16);
    test_output_holdoff();
    test_random_traffic(450, 0, 0);

    pair_ch.valid <= 1'b0;
    while (expected_touch.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d segment pairs, %0d of them touching.",
             results_checked, pairs_sent, touching_seen);
    $display("Input was held back for %0d cycles; %0d mismatches.",
             input_stall_cycles, mismatch_count);
    if (mismatch_count == 0 && expected_touch.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
